// ----- rtl/ubcd_pkg.sv -----
`timescale 1ns / 1ps

package ubcd_pkg;

	// Fixed field widths
	localparam int PIX_W  = 24;
	localparam int CFG_W  = 13;
	localparam int OUT_W  = 13;
	localparam int TDATA_W = 80;

	// Default largest image side
	localparam int DEF_MAX_DIM = 4096;

	// Register reset values
	localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

	// Register index codes
	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	// One frame result
	typedef struct packed {
		logic [OUT_W-1:0] left_border;
		logic [OUT_W-1:0] right_border;
		logic [OUT_W-1:0] top_border;
		logic [OUT_W-1:0] bottom_border;
		logic [OUT_W-1:0] new_width;
		logic [OUT_W-1:0] new_height;
		logic             crop_needed;
	} crop_result_t;

	// Map a register value to the working size: zero counts as one,
	// anything past the limit counts as the limit
	function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned max_dim);
		int unsigned val;
		val = int'(v);
		if (val == 0) begin
			return 1;
		end
		if (val > max_dim) begin
			return max_dim;
		end
		return val;
	endfunction

endpackage

// ----- rtl/ubcd_frame_close.sv -----
`timescale 1ns / 1ps

module ubcd_frame_close #(
	parameter int DW = 13
) (
	input  logic [DW-1:0]               width,
	input  logic [DW-1:0]               height,
	input  logic [DW-1:0]               leading_rows,
	input  logic [DW-1:0]               min_diff_column,
	input  logic [DW-1:0]               max_diff_column,
	input  logic [DW-1:0]               trailing_rows,
	output ubcd_pkg::crop_result_t      result
);
	import ubcd_pkg::*;

	logic           all_uniform;
	logic [DW-1:0]  left_b;
	logic [DW-1:0]  right_b;
	logic [DW:0]    col_sum;
	logic [DW:0]    row_sum;
	logic [DW-1:0]  nw;
	logic [DW-1:0]  nh;
	logic [DW-1:0]  left_o;
	logic [DW-1:0]  right_o;
	logic [DW-1:0]  top_o;
	logic [DW-1:0]  bottom_o;

	// Border sizes from the tracked columns and rows
	always_comb begin
		all_uniform = (leading_rows >= height);
		left_b  = min_diff_column;
		right_b = width - max_diff_column;
		col_sum = {1'b0, left_b} + {1'b0, right_b};
		row_sum = {1'b0, leading_rows} + {1'b0, trailing_rows};
		if (all_uniform) begin
			left_o   = '0;
			right_o  = '0;
			top_o    = '0;
			bottom_o = '0;
			nw       = width;
			nh       = height;
		end else begin
			left_o   = left_b;
			right_o  = right_b;
			top_o    = leading_rows;
			bottom_o = trailing_rows;
			// Overlapping runs leave an empty crop
			nw = (col_sum <= {1'b0, width}) ? (width - left_b - right_b) : '0;
			nh = (row_sum <= {1'b0, height}) ? (height - leading_rows - trailing_rows) : '0;
		end
	end

	// Widen to the result fields
	always_comb begin
		result.left_border   = OUT_W'(left_o);
		result.right_border  = OUT_W'(right_o);
		result.top_border    = OUT_W'(top_o);
		result.bottom_border = OUT_W'(bottom_o);
		result.new_width     = OUT_W'(nw);
		result.new_height    = OUT_W'(nh);
		result.crop_needed   = (nw != width) || (nh != height);
	end

endmodule

// ----- rtl/uniform_border_crop_detect.sv -----
`timescale 1ns / 1ps

// Uniform border detector for a raster-order pixel stream.
//
// Pixels enter on the s_ channel one per request, left to right and top to
// bottom, image_width pixels per row and image_height rows per frame. The
// block tracks the uniform top, left, right and bottom borders as pixels
// pass and emits one result request on the m_ channel for each frame.
//
// Throughput: one pixel per cycle, except while the last pixel of a frame
// is held off behind a waiting result. Every pixel is handled by compare
// and counter logic in the cycle it is accepted; the frame result is loaded
// into the output register on the edge that accepts the last pixel.
//
// Stall: while a result waits on m_tready, pixels of the next frame keep
// flowing; only the last pixel of that next frame is held off until the
// waiting result is taken.
//
// Reset: registers return to 640 x 480 and a fresh frame starts. Any write
// on the configuration port also restarts the frame, dropping pixels taken
// so far.
module uniform_border_crop_detect #(
	parameter int MAX_DIM = ubcd_pkg::DEF_MAX_DIM
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration writes
	input  logic                          wr_en,
	input  logic [0:0]                    wr_index,
	input  logic [ubcd_pkg::CFG_W-1:0]    wr_data,
	// Pixel input; tdata: pixel[23:0]
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [ubcd_pkg::PIX_W-1:0]    s_tdata,
	// Result output; tdata: left_border[12:0], right_border[25:13],
	// top_border[38:26], bottom_border[51:39], new_width[64:52],
	// new_height[77:65], crop_needed[78], zero pad[79]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ubcd_pkg::TDATA_W-1:0]  m_tdata
);
	import ubcd_pkg::*;

	localparam int REG_MAX = (1 << CFG_W) - 1;
	localparam int EFF_MAX = (MAX_DIM < REG_MAX) ? MAX_DIM : REG_MAX;
	localparam int DW      = $clog2(EFF_MAX + 1);
	localparam logic [DW-1:0] MIN_DIFF_RESET = DW'(clamp_dim(WIDTH_RESET, MAX_DIM));

	// Configuration and frame state
	logic [CFG_W-1:0] width_reg_q, height_reg_q;
	logic [DW-1:0]    col_q, row_q;
	logic [PIX_W-1:0] top_left_q, top_right_q, prev_pix_q;
	logic [DW-1:0]    lead_rows_q;
	logic             lead_open_q;
	logic [DW-1:0]    min_diff_q, max_diff_q;
	logic [PIX_W-1:0] row_first_q;
	logic             row_uni_q;
	logic [PIX_W-1:0] trail_color_q;
	logic [DW-1:0]    trail_rows_q;

	// Next state
	logic [CFG_W-1:0] width_reg_d, height_reg_d;
	logic [DW-1:0]    col_d, row_d;
	logic [PIX_W-1:0] top_left_d, top_right_d, prev_pix_d;
	logic [DW-1:0]    lead_rows_d;
	logic             lead_open_d;
	logic [DW-1:0]    min_diff_d, max_diff_d;
	logic [PIX_W-1:0] row_first_d;
	logic             row_uni_d;
	logic [PIX_W-1:0] trail_color_d;
	logic [DW-1:0]    trail_rows_d;

	// Values before the restart overrides, taken from the pixel update
	logic [DW-1:0] lead_rows_d_pre, min_diff_pre, max_diff_pre, trail_rows_pre;

	logic [DW-1:0]    w, h, w_next;
	logic             row_end, last_pix, in_req, frame_done, restart;
	logic [PIX_W-1:0] p;
	crop_result_t     result;

	logic                  m_valid_q;
	logic [TDATA_W-1:0]    m_data_q;

	assign w = DW'(clamp_dim(width_reg_q, MAX_DIM));
	assign h = DW'(clamp_dim(height_reg_q, MAX_DIM));
	assign p = s_tdata;

	assign row_end  = (col_q == w - DW'(1));
	assign last_pix = row_end && (row_q == h - DW'(1));

	// Hold off only the frame's last pixel while a result is still waiting
	assign s_tready   = !m_valid_q || m_tready || !last_pix;
	assign in_req     = s_tvalid && s_tready;
	assign frame_done = in_req && last_pix && !wr_en;

	// Per-pixel update
	always_comb begin
		width_reg_d   = width_reg_q;
		height_reg_d  = height_reg_q;
		col_d         = col_q;
		row_d         = row_q;
		top_left_d    = top_left_q;
		top_right_d   = top_right_q;
		prev_pix_d    = prev_pix_q;
		lead_rows_d   = lead_rows_q;
		lead_open_d   = lead_open_q;
		min_diff_d    = min_diff_q;
		max_diff_d    = max_diff_q;
		row_first_d   = row_first_q;
		row_uni_d     = row_uni_q;
		trail_color_d = trail_color_q;
		trail_rows_d  = trail_rows_q;
		restart       = 1'b0;

		if (in_req) begin
			// Row start color and uniform flag
			if (col_q == '0) begin
				row_first_d = p;
				row_uni_d   = 1'b1;
				if (row_q == '0) begin
					top_left_d = p;
				end
			end else if (p != row_first_q) begin
				row_uni_d = 1'b0;
			end

			// Leftmost column that differs from the top-left pixel
			if (p != top_left_d && col_q < min_diff_q) begin
				min_diff_d = col_q;
			end

			// Right border: start of the last run in row 0, then push right
			if (row_q == '0) begin
				if (col_q != '0 && p != prev_pix_q) begin
					max_diff_d = col_q;
				end
				if (row_end) begin
					top_right_d = p;
				end
			end else if (p != top_right_q && (col_q + DW'(1)) > max_diff_q) begin
				max_diff_d = col_q + DW'(1);
			end
			prev_pix_d = p;

			if (!row_end) begin
				col_d = col_q + DW'(1);
			end else begin
				col_d = '0;
				// Leading rows
				if (lead_open_q && row_uni_d && row_first_d == top_left_d) begin
					lead_rows_d = lead_rows_q + DW'(1);
				end else begin
					lead_open_d = 1'b0;
				end
				// Trailing rows
				if (row_uni_d) begin
					if (trail_rows_q != '0 && row_first_d == trail_color_q) begin
						trail_rows_d = trail_rows_q + DW'(1);
					end else begin
						trail_rows_d  = DW'(1);
						trail_color_d = row_first_d;
					end
				end else begin
					trail_rows_d = '0;
				end
				if (!last_pix) begin
					row_d = row_q + DW'(1);
				end else begin
					restart = 1'b0;
				end
			end
		end

		if (frame_done) begin
			restart = 1'b1;
		end

		// Register write restarts the frame
		if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				REG_IMAGE_WIDTH:  width_reg_d  = wr_data;
				REG_IMAGE_HEIGHT: height_reg_d = wr_data;
				default: ;
			endcase
			restart = 1'b1;
		end

		// Hand the closing state to the frame result
		lead_rows_d_pre = lead_rows_d;
		min_diff_pre    = min_diff_d;
		max_diff_pre    = max_diff_d;
		trail_rows_pre  = trail_rows_d;

		w_next = DW'(clamp_dim(width_reg_d, MAX_DIM));
		if (restart) begin
			col_d         = '0;
			row_d         = '0;
			top_left_d    = '0;
			top_right_d   = '0;
			prev_pix_d    = '0;
			lead_rows_d   = '0;
			lead_open_d   = 1'b1;
			min_diff_d    = w_next;
			max_diff_d    = '0;
			row_first_d   = '0;
			row_uni_d     = 1'b1;
			trail_color_d = '0;
			trail_rows_d  = '0;
		end
	end

	// Frame result from the state as updated by the last pixel
	ubcd_frame_close #(
		.DW (DW)
	) u_close (
		.width           (w),
		.height          (h),
		.leading_rows    (lead_rows_d_pre),
		.min_diff_column (min_diff_pre),
		.max_diff_column (max_diff_pre),
		.trailing_rows   (trail_rows_pre),
		.result          (result)
	);

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg_q   <= WIDTH_RESET;
			height_reg_q  <= HEIGHT_RESET;
			col_q         <= '0;
			row_q         <= '0;
			top_left_q    <= '0;
			top_right_q   <= '0;
			prev_pix_q    <= '0;
			lead_rows_q   <= '0;
			lead_open_q   <= 1'b1;
			min_diff_q    <= MIN_DIFF_RESET;
			max_diff_q    <= '0;
			row_first_q   <= '0;
			row_uni_q     <= 1'b1;
			trail_color_q <= '0;
			trail_rows_q  <= '0;
		end else begin
			width_reg_q   <= width_reg_d;
			height_reg_q  <= height_reg_d;
			col_q         <= col_d;
			row_q         <= row_d;
			top_left_q    <= top_left_d;
			top_right_q   <= top_right_d;
			prev_pix_q    <= prev_pix_d;
			lead_rows_q   <= lead_rows_d;
			lead_open_q   <= lead_open_d;
			min_diff_q    <= min_diff_d;
			max_diff_q    <= max_diff_d;
			row_first_q   <= row_first_d;
			row_uni_q     <= row_uni_d;
			trail_color_q <= trail_color_d;
			trail_rows_q  <= trail_rows_d;
		end
	end

	// Output register: load on the last pixel, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (frame_done) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_done) begin
			m_data_q <= {1'b0, result.crop_needed, result.new_height, result.new_width,
				result.bottom_border, result.top_border, result.right_border,
				result.left_border};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// A result appears only after the last pixel of a frame is taken
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(in_req && last_pix))
		else $error("result raised without a closing pixel");

	// A waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !m_tready && in_req) |-> !last_pix)
		else $error("last pixel accepted over a waiting result");

	// Column position stays inside the row
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q < w)
		else $error("column position past row width");

endmodule

// ----- dv/uniform_border_crop_detect_tb.sv -----
`timescale 1ns / 1ps

module uniform_border_crop_detect_tb;

	import ubcd_pkg::*;

	localparam int IDLE_PCT    = 13;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE      = 4;
	localparam int STALL_LIMIT = 4000;
	localparam int RAND_PIXELS = 1200;

	typedef enum {
		ST_BORDERED,
		ST_UNIFORM,
		ST_NOISE,
		ST_SPLIT_ROWS,
		ST_SPLIT_COLS
	} frame_style_t;

	logic                 clk;
	logic                 arst_n;
	logic                 wr_en;
	logic [0:0]           wr_index;
	logic [CFG_W-1:0]     wr_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [PIX_W-1:0]     s_tdata;   // pixel[23:0]
	logic                 m_tvalid;
	logic                 m_tready;
	logic [TDATA_W-1:0]   m_tdata;   // left, right, top, bottom, new_width, new_height, crop

	bit no_idle;
	bit hold_req;

	// Track border state per pixel and hold the crop results still owed
	class border_tracker;
		logic [CFG_W-1:0] cfg_w;
		logic [CFG_W-1:0] cfg_h;
		logic [11:0]      col;
		logic [11:0]      row;
		logic [23:0]      tl_color;
		logic [23:0]      tr_color;
		logic [23:0]      prev_px;
		logic [12:0]      lead_rows;
		logic             lead_open;
		logic [12:0]      first_diff;
		logic [12:0]      last_diff;
		logic [23:0]      row_color;
		logic             row_flat;
		logic [23:0]      tail_color;
		logic [12:0]      tail_rows;
		crop_result_t     crop_q[$];
		int               fails;

		function new();
			cfg_w = WIDTH_RESET;
			cfg_h = HEIGHT_RESET;
			fails = 0;
			restart();
		endfunction

		function int unsigned dim(logic [CFG_W-1:0] v);
			if (v == 0) return 1;
			if (v > DEF_MAX_DIM) return DEF_MAX_DIM;
			return v;
		endfunction

		function void restart();
			col = 0;
			row = 0;
			tl_color = 0;
			tr_color = 0;
			prev_px = 0;
			lead_rows = 0;
			lead_open = 1;
			first_diff = 13'(dim(cfg_w));
			last_diff = 0;
			row_color = 0;
			row_flat = 1;
			tail_color = 0;
			tail_rows = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] v);
			if (idx == REG_IMAGE_WIDTH) cfg_w = v;
			else cfg_h = v;
			restart();
		endfunction

		function void take_pixel(logic [23:0] p);
			int unsigned w, h, c, r, lft, rgt, top, bot, nw, nh;
			crop_result_t res;
			w = dim(cfg_w);
			h = dim(cfg_h);
			c = col;
			r = row;
			// row uniformity and the top-left reference
			if (c == 0) begin
				row_color = p;
				row_flat = 1;
				if (r == 0) tl_color = p;
			end else if (p != row_color) begin
				row_flat = 0;
			end
			if (p != tl_color && c < first_diff) first_diff = 13'(c);
			// right border: row 0 tracks the final run, later rows the top-right color
			if (r == 0) begin
				if (c > 0 && p != prev_px) last_diff = 13'(c);
				if (c + 1 >= w) tr_color = p;
			end else if (p != tr_color && c + 1 > last_diff) begin
				last_diff = 13'(c + 1);
			end
			prev_px = p;
			if (c + 1 < w) begin
				col = 12'(c + 1);
				return;
			end
			// end of row: update top and bottom run counts
			col = 0;
			if (lead_open && row_flat && row_color == tl_color) lead_rows++;
			else lead_open = 0;
			if (row_flat) begin
				if (tail_rows > 0 && row_color == tail_color) begin
					tail_rows++;
				end else begin
					tail_rows = 1;
					tail_color = row_color;
				end
			end else begin
				tail_rows = 0;
			end
			if (r + 1 < h) begin
				row = 12'(r + 1);
				return;
			end
			// end of frame: build the crop result
			if (lead_rows >= h) begin
				lft = 0; rgt = 0; top = 0; bot = 0;
				nw = w; nh = h;
			end else begin
				lft = first_diff;
				rgt = w - last_diff;
				top = lead_rows;
				bot = tail_rows;
				nw = (lft + rgt <= w) ? w - lft - rgt : 0;
				nh = (top + bot <= h) ? h - top - bot : 0;
			end
			res.left_border   = 13'(lft);
			res.right_border  = 13'(rgt);
			res.top_border    = 13'(top);
			res.bottom_border = 13'(bot);
			res.new_width     = 13'(nw);
			res.new_height    = 13'(nh);
			res.crop_needed   = (nw != w || nh != h);
			crop_q.push_back(res);
			restart();
		endfunction

		function void field_ok(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				fails++;
			end
		endfunction

		function void compare_crop(logic [TDATA_W-1:0] d);
			crop_result_t want;
			if (crop_q.size() == 0) begin
				$error("crop result with none expected: %h", d);
				fails++;
				return;
			end
			want = crop_q.pop_front();
			field_ok("left_border", want.left_border, d[12:0]);
			field_ok("right_border", want.right_border, d[25:13]);
			field_ok("top_border", want.top_border, d[38:26]);
			field_ok("bottom_border", want.bottom_border, d[51:39]);
			field_ok("new_width", want.new_width, d[64:52]);
			field_ok("new_height", want.new_height, d[77:65]);
			field_ok("crop_needed", want.crop_needed, d[78]);
		endfunction
	endclass

	border_tracker tracker = new();

	uniform_border_crop_detect dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// 4 ns clock
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Offer one pixel request, with random idle cycles ahead of it
	task automatic send_pixel(input logic [23:0] p);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= p;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		tracker.take_pixel(p);
	endtask

	// Drop valid, wait for every owed result, then let the block settle
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (tracker.crop_q.size() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] v);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= v;
		@(posedge clk);
		tracker.write_reg(idx, v);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
	endtask

	function automatic logic [CFG_W-1:0] pick_dim(int unsigned top);
		case ($urandom_range(15))
			0: return '0;
			1: return 13'd1;
			2: return 13'(top);
			default: return 13'($urandom_range(1, top));
		endcase
	endfunction

	// Build one frame at the current size and stream it
	task automatic send_frame(input frame_style_t style);
		int unsigned w, h, n_l, n_r, n_t, n_b, k, x, y;
		bit right_first;
		logic [23:0] mask, ca, cb, cc;
		logic [23:0] img[];
		w = tracker.dim(tracker.cfg_w);
		h = tracker.dim(tracker.cfg_h);
		case ($urandom_range(2))
			0: mask = 24'hFF;
			1: mask = 24'hFFFF;
			default: mask = 24'hFFFFFF;
		endcase
		ca = 24'($urandom) & mask;
		cb = 24'($urandom) & mask;
		cc = 24'($urandom) & mask;
		if ($urandom_range(3) == 0) begin
			cb = ca;
			cc = ca;
		end
		img = new[w * h];
		// background from a small palette, with extremes and random values
		for (int i = 0; i < w * h; i++) begin
			case ($urandom_range(5))
				0: img[i] = ca;
				1: img[i] = cb;
				2: img[i] = cc;
				3: img[i] = 24'($urandom) & mask;
				default: img[i] = $urandom_range(1) ? mask : 24'h0;
			endcase
		end
		case (style)
			ST_BORDERED: begin
				n_t = $urandom_range(h);
				n_b = $urandom_range(h);
				n_l = $urandom_range(w);
				n_r = $urandom_range(w);
				right_first = $urandom_range(1);
				for (y = 0; y < h; y++) begin
					for (x = 0; x < w; x++) begin
						if (right_first && x >= w - n_r) img[y * w + x] = cb;
						else if (y < n_t || x < n_l) img[y * w + x] = ca;
						else if (x >= w - n_r) img[y * w + x] = cb;
						else if (y >= h - n_b) img[y * w + x] = cc;
					end
				end
				if ($urandom_range(5) == 0) img[$urandom_range(w * h - 1)] = 24'($urandom);
			end
			ST_UNIFORM: begin
				foreach (img[i]) img[i] = ca;
			end
			ST_NOISE: begin
				foreach (img[i]) img[i] = 24'($urandom);
			end
			ST_SPLIT_ROWS: begin
				k = (h > 1) ? $urandom_range(1, h - 1) : 0;
				cc = ~ca & mask;
				foreach (img[i]) img[i] = (i / w < k) ? ca : cc;
			end
			default: begin
				k = (w > 1) ? $urandom_range(1, w - 1) : 0;
				cb = ~ca & mask;
				foreach (img[i]) img[i] = (i % w < k) ? ca : cb;
			end
		endcase
		foreach (img[i]) send_pixel(img[i]);
	endtask

	// Result side: random stalls, one long hold-off on request
	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) tracker.compare_crop(m_tdata);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= no_idle || $urandom_range(99) >= IDLE_PCT;
			end
		end
	end

	// End the run when no request moves for too long
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
			else quiet_cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		int unsigned rand_px, k, r;
		frame_style_t st;
		arst_n <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= REG_IMAGE_WIDTH;
		wr_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		no_idle = 1'b0;
		hold_req = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Height keeps its reset value: one column of 480 rows
		write_reg(REG_IMAGE_WIDTH, 1);
		send_frame(ST_BORDERED);
		// Zero sizes count as one
		set_size(0, 0);
		send_pixel(24'hFFFFFF);
		set_size(1, 1);
		send_pixel(24'h000000);
		// All uniform frame
		set_size(4, 3);
		send_frame(ST_UNIFORM);
		// Empty crop by rows, then by columns
		set_size(3, 2);
		send_frame(ST_SPLIT_ROWS);
		set_size(2, 2);
		send_frame(ST_SPLIT_COLS);
		set_size(5, 4);
		send_frame(ST_BORDERED);
		send_frame(ST_NOISE);
		// Write in mid-frame drops the partial frame
		set_size(3, 3);
		repeat (4) send_pixel(24'($urandom));
		wait_idle();
		write_reg(REG_IMAGE_HEIGHT, 3);
		send_frame(ST_BORDERED);

		// Random frames of small sizes
		set_size(pick_dim(10), pick_dim(8));
		rand_px = 0;
		k = 0;
		while (rand_px < RAND_PIXELS) begin
			no_idle = (k >= 16 && k < 32);
			if (k == 12) hold_req = 1'b1;
			if ((k < 10 || k > 22) && $urandom_range(2) == 0) begin
				wait_idle();
				case ($urandom_range(2))
					0: write_reg(REG_IMAGE_WIDTH, pick_dim(10));
					1: write_reg(REG_IMAGE_HEIGHT, pick_dim(8));
					default: begin
						write_reg(REG_IMAGE_WIDTH, pick_dim(10));
						write_reg(REG_IMAGE_HEIGHT, pick_dim(8));
					end
				endcase
			end
			r = $urandom_range(9);
			if (r < 6) st = ST_BORDERED;
			else if (r == 6) st = ST_UNIFORM;
			else if (r == 7) st = ST_NOISE;
			else if (r == 8) st = ST_SPLIT_ROWS;
			else st = ST_SPLIT_COLS;
			rand_px += tracker.dim(tracker.cfg_w) * tracker.dim(tracker.cfg_h);
			send_frame(st);
			k++;
		end
		no_idle = 1'b0;
		wait_idle();
		repeat (10) @(posedge clk);

		if (tracker.crop_q.size() > 0) begin
			$error("%0d crop results never arrived", tracker.crop_q.size());
			tracker.fails++;
		end
		if (tracker.fails == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
